>>> rtl/ptbb_pkg.sv
// Shared types and constants for the point table with bounding box.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package ptbb_pkg;

    localparam int COORD_BITS  = 16;
    localparam int OP_W        = 2;
    localparam int POS_W       = 6;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int CAPACITY    = 64;

    localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_PT  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_POS = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic [OP_W-1:0]              operation;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [POS_W-1:0]             position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [COUNT_W-1:0]           entry_count;
        logic                         box_valid;
        logic signed [COORD_BITS-1:0] box_min_x;
        logic signed [COORD_BITS-1:0] box_max_x;
        logic signed [COORD_BITS-1:0] box_min_y;
        logic signed [COORD_BITS-1:0] box_max_y;
        logic signed [COORD_BITS-1:0] box_min_z;
        logic signed [COORD_BITS-1:0] box_max_z;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                ins_wr;
        logic                idx_load_pos;
        logic                idx_inc;
        logic                rd_next;
        logic                shift_wr;
        logic                cnt_dec;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                finish;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            pos_ok;
        logic            scan_end;
        logic            match;
        logic            more;
    } t_dp_sts;

endpackage

>>> rtl/point_table_with_bounding_box.sv
// Point table with running bounding box, top level.
// Instantiates ptbb_ctrl and ptbb_dp; types and constants come from ptbb_pkg.
//
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy
//   is low; i_item carries the operation, the coordinates and the position.
//   Exactly one result follows on o_result, marked by o_strobe for a single
//   cycle. The receiver cannot hold results off; busy is low again in the
//   cycle the strobe is shown, so the next transaction may start then.
// Sequence (start edge to strobe):
//   insert, refused insert, bad position or unknown code: dispatch, then finish.
//   remove by position p: dispatch, then shift every entry above p one place lower.
//   remove by coordinates: search from entry 0 until a match, then shift the
//   later entries down as above; with no match the search runs to the count.
//   The point memory has one registered read port and one write port: the
//   search reads an entry and then compares it, and the shift reads one entry
//   and then writes it one place lower.
// Reset (synchronous, active low) empties the table and returns the box to
//   most positive minimums and most negative maximums; no clearing pass is
//   needed since entries at or above the count are never used.
module point_table_with_bounding_box #(
    parameter int CAPACITY = ptbb_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ptbb_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output ptbb_pkg::t_out_item o_result
);

    ptbb_pkg::t_cmd    cmd;
    ptbb_pkg::t_dp_sts sts;

    ptbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ptbb_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

>>> rtl/ptbb_ctrl.sv
// Controller state machine for the point table: sequences insert, search and
// order-keeping shift. Depends on ptbb_pkg for the state, command and status types.
module ptbb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ptbb_pkg::t_dp_sts i_sts,
    output ptbb_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    ptbb_pkg::t_state r_state;
    ptbb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptbb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ptbb_pkg::S_IDLE);
        case (r_state)
            ptbb_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ptbb_pkg::S_DISPATCH;
                end
            end
            ptbb_pkg::S_DISPATCH: begin
                n_state = ptbb_pkg::S_FINISH;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ptbb_pkg::STAT_MISS;
                case (i_sts.op)
                    ptbb_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.status = ptbb_pkg::STAT_FULL;
                        end else begin
                            o_cmd.ins_wr = 1'b1;
                            o_cmd.status = ptbb_pkg::STAT_OK;
                        end
                    end
                    ptbb_pkg::OP_REMOVE_PT: begin
                        o_cmd.set_status = 1'b0;
                        n_state          = ptbb_pkg::S_SCAN_RD;
                    end
                    ptbb_pkg::OP_REMOVE_POS: begin
                        if (i_sts.pos_ok) begin
                            o_cmd.set_status   = 1'b0;
                            o_cmd.idx_load_pos = 1'b1;
                            n_state            = ptbb_pkg::S_SHIFT_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ptbb_pkg::S_SCAN_RD: begin
                // The entry at the index is read here and, unless the scan is at the count, compared next cycle.
                if (i_sts.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ptbb_pkg::STAT_MISS;
                    n_state          = ptbb_pkg::S_FINISH;
                end else begin
                    n_state = ptbb_pkg::S_SCAN_CMP;
                end
            end
            ptbb_pkg::S_SCAN_CMP: begin
                if (i_sts.match) begin
                    n_state = ptbb_pkg::S_SHIFT_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ptbb_pkg::S_SCAN_RD;
                end
            end
            ptbb_pkg::S_SHIFT_RD: begin
                if (i_sts.more) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = ptbb_pkg::S_SHIFT_WR;
                end else begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ptbb_pkg::STAT_OK;
                    n_state          = ptbb_pkg::S_FINISH;
                end
            end
            ptbb_pkg::S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = ptbb_pkg::S_SHIFT_RD;
            end
            ptbb_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ptbb_pkg::S_IDLE;
            end
            default: begin
                n_state = ptbb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ptbb_dp.sv
// Datapath for the point table: point memory, count, scan index, bounding box
// and the result register. Depends on ptbb_pkg; driven by ptbb_ctrl commands.
module ptbb_dp #(
    parameter int CAPACITY = ptbb_pkg::CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptbb_pkg::t_in_item  i_item,
    input  ptbb_pkg::t_cmd      i_cmd,
    output ptbb_pkg::t_dp_sts   o_sts,
    output logic                o_strobe,
    output ptbb_pkg::t_out_item o_result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (CNT_W > ptbb_pkg::POS_W) ? CNT_W : ptbb_pkg::POS_W;
    localparam int CB    = ptbb_pkg::COORD_BITS;

    ptbb_pkg::t_point r_mem [CAPACITY];
    ptbb_pkg::t_point r_rdata;
    ptbb_pkg::t_point r_pt;
    ptbb_pkg::t_point wr_data;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [CNT_W:0]   idx_plus;

    logic [ptbb_pkg::OP_W-1:0]     r_op;
    logic [ptbb_pkg::POS_W-1:0]    r_pos;
    logic [ptbb_pkg::STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              r_idx;
    logic signed [CB-1:0]          r_low [3];
    logic signed [CB-1:0]          r_high [3];
    logic signed [CB-1:0]          in_c [3];
    logic                          r_strobe;
    ptbb_pkg::t_out_item           r_result;

    assign idx_plus = {1'b0, r_idx} + (CNT_W + 1)'(1);
    assign rd_addr  = i_cmd.rd_next ? idx_plus[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign wr_en    = i_cmd.ins_wr | i_cmd.shift_wr;
    assign wr_addr  = i_cmd.ins_wr ? r_cnt[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign wr_data  = i_cmd.ins_wr ? r_pt : r_rdata;

    assign in_c[0] = r_pt.x;
    assign in_c[1] = r_pt.y;
    assign in_c[2] = r_pt.z;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.operation;
            r_pos  <= i_item.position;
            r_pt.x <= i_item.coord_x;
            r_pt.y <= i_item.coord_y;
            r_pt.z <= i_item.coord_z;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.idx_load_pos) begin
            r_idx <= CNT_W'(r_pos);
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_plus[CNT_W-1:0];
        end
        if (i_cmd.finish) begin
            r_result.status      <= r_status;
            r_result.entry_count <= ptbb_pkg::COUNT_W'(r_cnt);
            r_result.box_valid   <= (r_low[0] <= r_high[0]);
            r_result.box_min_x   <= r_low[0];
            r_result.box_max_x   <= r_high[0];
            r_result.box_min_y   <= r_low[1];
            r_result.box_max_y   <= r_high[1];
            r_result.box_min_z   <= r_low[2];
            r_result.box_max_z   <= r_high[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_low[k]  <= ptbb_pkg::COORD_MAXV;
                r_high[k] <= ptbb_pkg::COORD_MINV;
            end
        end else begin
            r_strobe <= i_cmd.finish;
            if (i_cmd.ins_wr) begin
                r_cnt <= r_cnt + CNT_W'(1);
                for (int k = 0; k < 3; k++) begin
                    if (in_c[k] < r_low[k]) begin
                        r_low[k] <= in_c[k];
                    end
                    if (in_c[k] > r_high[k]) begin
                        r_high[k] <= in_c[k];
                    end
                end
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.full     = (r_cnt == CNT_W'(CAPACITY));
    assign o_sts.pos_ok   = (PW'(r_pos) < PW'(r_cnt));
    assign o_sts.scan_end = (r_idx >= r_cnt);
    assign o_sts.match    = (r_rdata == r_pt);
    assign o_sts.more     = (idx_plus < {1'b0, r_cnt});

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> rtl/ptbb_checker.sv
// Port-level checker for the point table with bounding box, bound to the top.
// Depends on ptbb_pkg for the payload types and status codes.
module ptbb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input ptbb_pkg::t_out_item o_result
);

    // An accepted transaction always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted transaction");

    // A result is only shown once the block has gone back to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // Each transaction passes the dispatch and finish states, so results never come back to back.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on two consecutive cycles");

    // Without any insert the table must be empty.
    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.box_valid) |-> (o_result.entry_count == '0))
        else $error("entries present while the box is still empty");

    // A successful insert or removal implies a point has been inserted, so the box is valid.
    a_ok_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ptbb_pkg::STAT_OK) |-> o_result.box_valid)
        else $error("successful transaction with an empty box");

endmodule

bind point_table_with_bounding_box ptbb_checker u_ptbb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

>>> tb/tb_point_table_with_bounding_box.sv
// Testbench for point_table_with_bounding_box: a directed pass plus paced random traffic.
// A small tracker class mirrors the table and the box and checks every reported result.
// Depends on ptbb_pkg and the block's RTL.
module tb_point_table_with_bounding_box;
    timeunit 1ns;
    timeprecision 1ps;

    import ptbb_pkg::*;

    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int RANDOM_PER_PHASE = 510;

    // The one operation code that has no meaning; the block must report a miss for it.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Mirror of the table contents and the running box, plus the queue of reports
    // that the block still owes.
    class box_table_tracker;
        t_point    rows [CAPACITY];
        int        fill;
        t_point    lo_corner;
        t_point    hi_corner;
        t_out_item owed_reports [$];
        int        errors;
        int        transactions;
        int        refused_full;
        int        misses;
        int        peak_fill;

        function new();
            fill = 0;
            lo_corner = {COORD_MAXV, COORD_MAXV, COORD_MAXV};
            hi_corner = {COORD_MINV, COORD_MINV, COORD_MINV};
            errors = 0;
            transactions = 0;
            refused_full = 0;
            misses = 0;
            peak_fill = 0;
        endfunction

        // Removal keeps the order: every later row moves down one place.
        function void drop_row(int idx);
            for (int i = idx; i + 1 < fill; i++) begin
                rows[i] = rows[i + 1];
            end
            fill--;
        endfunction

        function void note_request(t_in_item req);
            t_out_item rep;
            t_point    p;
            int        hit;
            p = {req.coord_x, req.coord_y, req.coord_z};
            rep = '0;
            rep.status = STAT_MISS;
            hit = -1;
            case (req.operation)
                OP_INSERT: begin
                    if (fill >= CAPACITY) begin
                        rep.status = STAT_FULL;
                    end else begin
                        rows[fill] = p;
                        if ($signed(p.x) < $signed(lo_corner.x)) lo_corner.x = p.x;
                        if ($signed(p.y) < $signed(lo_corner.y)) lo_corner.y = p.y;
                        if ($signed(p.z) < $signed(lo_corner.z)) lo_corner.z = p.z;
                        if ($signed(p.x) > $signed(hi_corner.x)) hi_corner.x = p.x;
                        if ($signed(p.y) > $signed(hi_corner.y)) hi_corner.y = p.y;
                        if ($signed(p.z) > $signed(hi_corner.z)) hi_corner.z = p.z;
                        fill++;
                        rep.status = STAT_OK;
                    end
                end
                OP_REMOVE_PT: begin
                    for (int i = 0; i < fill; i++) begin
                        if (hit < 0 && rows[i] == p) hit = i;
                    end
                    if (hit >= 0) begin
                        drop_row(hit);
                        rep.status = STAT_OK;
                    end
                end
                OP_REMOVE_POS: begin
                    if (int'(req.position) < fill) begin
                        drop_row(int'(req.position));
                        rep.status = STAT_OK;
                    end
                end
                default: begin
                end
            endcase
            rep.entry_count = fill[COUNT_W-1:0];
            rep.box_valid   = ($signed(lo_corner.x) <= $signed(hi_corner.x));
            rep.box_min_x   = lo_corner.x;
            rep.box_max_x   = hi_corner.x;
            rep.box_min_y   = lo_corner.y;
            rep.box_max_y   = hi_corner.y;
            rep.box_min_z   = lo_corner.z;
            rep.box_max_z   = hi_corner.z;
            transactions++;
            if (rep.status == STAT_FULL) refused_full++;
            if (rep.status == STAT_MISS) misses++;
            if (fill > peak_fill) peak_fill = fill;
            owed_reports = {owed_reports, rep};
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (owed_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
                want = owed_reports.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("entry_count", want.entry_count, got.entry_count);
                compare_field("box_valid", want.box_valid, got.box_valid);
                compare_field("box_min_x", $signed(want.box_min_x), $signed(got.box_min_x));
                compare_field("box_max_x", $signed(want.box_max_x), $signed(got.box_max_x));
                compare_field("box_min_y", $signed(want.box_min_y), $signed(got.box_min_y));
                compare_field("box_max_y", $signed(want.box_max_y), $signed(got.box_max_y));
                compare_field("box_min_z", $signed(want.box_min_z), $signed(got.box_min_z));
                compare_field("box_max_z", $signed(want.box_max_z), $signed(got.box_max_z));
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    box_table_tracker tracker = new();

    point_table_with_bounding_box dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) tracker.check_report(o_result);
    end

    function automatic t_in_item mk(logic [OP_W-1:0] op, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z, logic [POS_W-1:0] pos);
        t_in_item req;
        req.operation = op;
        req.coord_x   = x;
        req.coord_y   = y;
        req.coord_z   = z;
        req.position  = pos;
        return req;
    endfunction

    // Mix of full-range values, a tight cluster that produces duplicates, and the extremes.
    function automatic logic [15:0] rand_coord();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom_range(6)) - 16'd3;
            1: begin
                case ($urandom_range(3))
                    0: v = COORD_MAXV;
                    1: v = COORD_MINV;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: v = 16'($urandom_range(65535));
        endcase
        return v;
    endfunction

    function automatic t_in_item make_random(int insert_pct);
        t_in_item req;
        int       r;
        t_point   p;
        r = $urandom_range(99);
        req = mk(OP_INSERT, rand_coord(), rand_coord(), rand_coord(),
                 POS_W'($urandom_range(63)));
        if (r >= 97) begin
            req.operation = OP_UNKNOWN;
        end else if (r >= insert_pct) begin
            if ($urandom_range(1) == 0) begin
                req.operation = OP_REMOVE_PT;
                if (tracker.fill > 0 && $urandom_range(99) < 60) begin
                    p = tracker.rows[$urandom_range(tracker.fill - 1)];
                    req.coord_x = p.x;
                    req.coord_y = p.y;
                    req.coord_z = p.z;
                end
            end else begin
                req.operation = OP_REMOVE_POS;
                if (tracker.fill > 0 && $urandom_range(99) < 70)
                    req.position = POS_W'($urandom_range(tracker.fill - 1));
            end
        end
        return req;
    endfunction

    // Presents one transaction and returns at the edge that accepts it, with start
    // still high so that a following transaction can go out back to back.
    task automatic send_item(input t_in_item req);
        start  <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (busy);
        tracker.note_request(req);
    endtask

    task automatic pause_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.owed_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int max_gap);
        int counted;
        int seg_left;
        int insert_pct;
        t_in_item req;
        counted = 0;
        seg_left = 0;
        insert_pct = 50;
        while (counted < RANDOM_PER_PHASE) begin
            // Switch among filling, balanced and draining stretches so the table reaches full and empty.
            if (seg_left == 0) begin
                seg_left = $urandom_range(120, 40);
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 20;
                endcase
            end
            seg_left--;
            if ($urandom_range(99) < idle_pct) pause_cycles($urandom_range(max_gap, 1));
            req = make_random(insert_pct);
            send_item(req);
            if (req.operation != OP_UNKNOWN) counted++;
            if (counted == RANDOM_PER_PHASE / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        t_in_item directed [$];
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd0)};
        directed = {directed, mk(OP_REMOVE_PT, 16'h0000, 16'h0000, 16'h0000, 6'd0)};
        directed = {directed, mk(OP_UNKNOWN, 16'h1234, 16'h8000, 16'h7FFF, 6'd63)};
        directed = {directed, mk(OP_INSERT, COORD_MAXV, COORD_MAXV, COORD_MAXV, 6'd63)};
        directed = {directed, mk(OP_INSERT, COORD_MINV, COORD_MINV, COORD_MINV, 6'd0)};
        directed = {directed, mk(OP_INSERT, 16'h0000, 16'hFFFF, 16'h0001, 6'd0)};
        directed = {directed, mk(OP_INSERT, 16'h0000, 16'hFFFF, 16'h0001, 6'd42)};
        directed = {directed, mk(OP_INSERT, 16'h0005, 16'hFFFB, 16'h0005, 6'd21)};
        directed = {directed, mk(OP_REMOVE_PT, 16'h0000, 16'hFFFF, 16'h0001, 6'd0)};
        directed = {directed, mk(OP_REMOVE_PT, 16'h0001, 16'h0002, 16'h0003, 6'd0)};
        directed = {directed, mk(OP_REMOVE_PT, 16'h0000, 16'hFFFF, 16'h0002, 6'd0)};
        directed = {directed, mk(OP_REMOVE_POS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63)};
        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd4)};
        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd3)};
        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd0)};
        directed = {directed, mk(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0)};
        directed = {directed, mk(OP_REMOVE_PT, 16'h0000, 16'hFFFF, 16'h0001, 6'd0)};
        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd0)};
        directed = {directed, mk(OP_REMOVE_POS, 16'h0000, 16'h0000, 16'h0000, 6'd0)};
        directed = {directed, mk(OP_INSERT, 16'hFFFF, 16'h0000, 16'h8001, 6'd0)};
        directed = {directed, mk(OP_REMOVE_PT, 16'hFFFF, 16'h0000, 16'h8001, 6'd0)};
        foreach (directed[i]) send_item(directed[i]);
        wait_drained();

        run_phase(10, 3);
        run_phase(88, 8);
        run_phase(0, 1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d transactions in three pacing phases, peak table count %0d.",
                 tracker.transactions, tracker.peak_fill);
        $display("Inserts refused on a full table: %0d; misses and unknown codes: %0d.",
                 tracker.refused_full, tracker.misses);
        if (tracker.errors == 0 && tracker.owed_reports.size() == 0) begin
            $display("point_table_with_bounding_box: match");
        end else begin
            $display("point_table_with_bounding_box: mismatch");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Timed out with %0d results outstanding.", tracker.owed_reports.size());
        $display("point_table_with_bounding_box: mismatch");
        $finish;
    end

endmodule

>>> point_table_with_bounding_box.f
rtl/ptbb_pkg.sv
rtl/ptbb_ctrl.sv
rtl/ptbb_dp.sv
rtl/point_table_with_bounding_box.sv
rtl/ptbb_checker.sv
tb/tb_point_table_with_bounding_box.sv
